// ----- rtl/hhlu_pkg.sv -----
`timescale 1ns / 1ps

package hhlu_pkg;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_LC_H  = 8'h68;
   localparam logic [7:0] CH_LC_T  = 8'h74;
   localparam logic [7:0] CH_LC_P  = 8'h70;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5a;
   localparam logic [7:0] CASE_OFS = 8'h20;

   // number of signature bytes that must follow the slop
   localparam int SIG_LEN = 4;

   typedef struct packed {
      logic prev_cont;
      logic join_line;
      logic strip;
      logic open;
      logic cand;
      logic colon;
   } line_state_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UC_A && c <= CH_UC_Z) begin
         r = c + CASE_OFS;
      end
      return r;
   endfunction

endpackage

// ----- rtl/http_header_line_unfolder.sv -----
`timescale 1ns / 1ps

// Header line unfolder. Raw header octets enter on the req_ channel, one per
// transaction; req_tlast closes a message and req_tuser says whether req_tdata
// carries a byte (a closing transaction may be empty). The assembled header
// text leaves on the rsp_ channel, one octet per transaction, with rsp_tlast on
// the second closing NUL of each message.
// The first output octet of an accepted byte passes the input register and then
// the result register, out of which it is valid on rsp_.
// With rsp_tready high one byte is taken per cycle; a line start that emits
// NUL plus the byte holds the input while the byte waits in the pending stage.
// The first SLOP_MAX+4 bytes are held; when they are resolved the block runs
// the slop search and replays the held bytes from the found offset on, with a
// NUL ahead of each line start among them, and the close of a message emits
// its two NULs; no byte is taken meanwhile.
// Reset clears the hold buffer count, the line state and both registers.
// When the receiver stalls, the result register and a one-octet pending stage
// hold their data, the engine stops and req_tready drops once the input
// register is full; nothing is lost or repeated.
module http_header_line_unfolder #(
   parameter int SLOP_MAX = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_byte
   input  logic       req_tuser,   // has_byte
   input  logic       req_tlast,   // end_of_message
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tlast    // out_last
);

   localparam int HOLD_LEN = SLOP_MAX + hhlu_pkg::SIG_LEN;
   localparam int IDX_W    = $clog2(HOLD_LEN);
   localparam int CNT_W    = $clog2(HOLD_LEN + 1);

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_STATUS,
      PH_LINES
   } phase_type;

   typedef enum logic [1:0] {
      M_RUN,
      M_RESOLVE,
      M_REPLAY,
      M_CLOSE
   } mode_type;

   // input register
   logic       in_v_ff, in_v_in;
   logic [7:0] in_data_ff;
   logic       in_has_ff;
   logic       in_last_ff;
   logic       in_take;

   // result register and pending octet
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       pend_v_ff, pend_v_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic       pend_last_ff, pend_last_in;
   logic       emit;
   logic       out_free;

   // engine state
   mode_type                 mode_ff, mode_in;
   phase_type                phase_ff, phase_in;
   hhlu_pkg::line_state_type ls_ff, ls_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     close_ff, close_in;

   // hold buffer
   logic [7:0]       la_ff [HOLD_LEN];
   logic             la_we;
   logic [IDX_W-1:0] skip;

   // line logic
   logic [7:0]               lb_c;
   logic                     lb_blank;
   logic                     lb_eol;
   hhlu_pkg::line_state_type lb_state;
   phase_type                lb_phase;
   logic [1:0]               lb_n;
   logic [7:0]               lb_b0;
   logic [7:0]               lb_b1;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_v_ff || in_take;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // slop search: smallest offset with a case-insensitive signature match
   always_comb begin
      skip = '0;
      for (int i = SLOP_MAX; i >= 0; i--) begin
         if (cnt_ff >= CNT_W'(i + hhlu_pkg::SIG_LEN) &&
             hhlu_pkg::to_lower(la_ff[i])     == hhlu_pkg::CH_LC_H &&
             hhlu_pkg::to_lower(la_ff[i + 1]) == hhlu_pkg::CH_LC_T &&
             hhlu_pkg::to_lower(la_ff[i + 2]) == hhlu_pkg::CH_LC_T &&
             hhlu_pkg::to_lower(la_ff[i + 3]) == hhlu_pkg::CH_LC_P) begin
            skip = IDX_W'(i);
         end
      end
   end

   assign lb_c     = (mode_ff == M_REPLAY) ? la_ff[idx_ff] : in_data_ff;
   assign lb_blank = (lb_c == hhlu_pkg::CH_SP) || (lb_c == hhlu_pkg::CH_TAB);
   assign lb_eol   = (lb_c == hhlu_pkg::CH_CR) || (lb_c == hhlu_pkg::CH_LF);

   always_comb begin
      lb_state = ls_ff;
      lb_phase = phase_ff;
      lb_n     = 2'd0;
      lb_b0    = lb_c;
      lb_b1    = lb_c;
      if (phase_ff == PH_STATUS) begin
         if (lb_eol) begin
            lb_phase = PH_LINES;
         end else begin
            lb_n = 2'd1;
         end
      end else if (lb_eol) begin
         if (ls_ff.open) begin
            if (!ls_ff.join_line) begin
               lb_state.prev_cont = ls_ff.cand && ls_ff.colon;
            end
            lb_state.open      = 1'b0;
            lb_state.cand      = 1'b0;
            lb_state.join_line = 1'b0;
            lb_state.strip     = 1'b0;
            lb_state.colon     = 1'b0;
         end
      end else if (!ls_ff.open) begin
         if (ls_ff.prev_cont && lb_blank) begin
            lb_state.join_line = 1'b1;
            lb_state.strip     = 1'b1;
            lb_state.open      = 1'b1;
            lb_state.cand      = 1'b0;
            lb_n  = 2'd1;
            lb_b0 = hhlu_pkg::CH_SP;
         end else begin
            lb_state.join_line = 1'b0;
            lb_state.strip     = 1'b0;
            lb_state.colon     = 1'b0;
            lb_state.open      = 1'b1;
            lb_state.cand      = !lb_blank && (lb_c != hhlu_pkg::CH_COLON);
            lb_n  = 2'd2;
            lb_b0 = hhlu_pkg::CH_NUL;
         end
      end else if (ls_ff.join_line) begin
         if (!(ls_ff.strip && lb_blank)) begin
            lb_state.strip = 1'b0;
            lb_n = 2'd1;
         end
      end else begin
         lb_n = 2'd1;
         if (lb_c == hhlu_pkg::CH_COLON) begin
            lb_state.colon = 1'b1;
         end
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      ls_in        = ls_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      close_in     = close_ff;
      pend_v_in    = pend_v_ff;
      pend_byte_in = pend_byte_ff;
      pend_last_in = pend_last_ff;
      in_take      = 1'b0;
      la_we        = 1'b0;
      emit         = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (out_free) begin
         if (pend_v_ff) begin
            emit        = 1'b1;
            rsp_data_in = pend_byte_ff;
            rsp_last_in = pend_last_ff;
            pend_v_in   = 1'b0;
         end else begin
            case (mode_ff)
               M_RESOLVE: begin
                  phase_in = PH_STATUS;
                  if (cnt_ff == '0) begin
                     mode_in = close_ff ? M_CLOSE : M_RUN;
                  end else begin
                     idx_in  = skip;
                     mode_in = M_REPLAY;
                  end
               end
               M_REPLAY: begin
                  ls_in    = lb_state;
                  phase_in = lb_phase;
                  if (lb_n != 2'd0) begin
                     emit        = 1'b1;
                     rsp_data_in = lb_b0;
                     rsp_last_in = 1'b0;
                  end
                  if (lb_n == 2'd2) begin
                     pend_v_in    = 1'b1;
                     pend_byte_in = lb_b1;
                     pend_last_in = 1'b0;
                  end
                  if (CNT_W'(idx_ff) + CNT_W'(1) == cnt_ff) begin
                     cnt_in  = '0;
                     mode_in = close_ff ? M_CLOSE : M_RUN;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
               M_CLOSE: begin
                  emit         = 1'b1;
                  rsp_data_in  = hhlu_pkg::CH_NUL;
                  rsp_last_in  = 1'b0;
                  pend_v_in    = 1'b1;
                  pend_byte_in = hhlu_pkg::CH_NUL;
                  pend_last_in = 1'b1;
                  phase_in     = PH_PREFIX;
                  ls_in        = '0;
                  cnt_in       = '0;
                  close_in     = 1'b0;
                  mode_in      = M_RUN;
               end
               M_RUN: begin
                  if (in_v_ff) begin
                     in_take = 1'b1;
                     if (phase_ff == PH_PREFIX) begin
                        if (in_has_ff) begin
                           la_we  = 1'b1;
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                        if ((in_has_ff && cnt_ff + CNT_W'(1) == CNT_W'(HOLD_LEN)) ||
                            in_last_ff) begin
                           mode_in  = M_RESOLVE;
                           close_in = in_last_ff;
                        end
                     end else begin
                        if (in_has_ff) begin
                           ls_in    = lb_state;
                           phase_in = lb_phase;
                           if (lb_n != 2'd0) begin
                              emit        = 1'b1;
                              rsp_data_in = lb_b0;
                              rsp_last_in = 1'b0;
                           end
                           if (lb_n == 2'd2) begin
                              pend_v_in    = 1'b1;
                              pend_byte_in = lb_b1;
                              pend_last_in = 1'b0;
                           end
                        end
                        if (in_last_ff) begin
                           mode_in = M_CLOSE;
                        end
                     end
                  end
               end
               default: begin
                  mode_in = M_RUN;
               end
            endcase
         end
      end
   end

   assign in_v_in      = (req_tvalid && req_tready) ? 1'b1 : (in_take ? 1'b0 : in_v_ff);
   assign rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= hhlu_pkg::CH_NUL;
         rsp_last_ff  <= 1'b0;
         pend_v_ff    <= 1'b0;
         mode_ff      <= M_RUN;
         phase_ff     <= PH_PREFIX;
         ls_ff        <= '0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         close_ff     <= 1'b0;
      end else begin
         in_v_ff      <= in_v_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_last_ff  <= rsp_last_in;
         pend_v_ff    <= pend_v_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         ls_ff        <= ls_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         close_ff     <= close_in;
      end
   end

   // payload registers and hold buffer
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_has_ff  <= req_tuser;
         in_last_ff <= req_tlast;
      end
      pend_byte_ff <= pend_byte_in;
      pend_last_ff <= pend_last_in;
      if (la_we) begin
         la_ff[cnt_ff[IDX_W-1:0]] <= in_data_ff;
      end
   end

   a_last_is_nul: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == hhlu_pkg::CH_NUL)
      else $error("closing transaction carries a non-NUL octet");

   a_pend_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> rsp_valid_ff)
      else $error("pending octet without an occupied result register");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(HOLD_LEN))
      else $error("hold count beyond buffer depth");

   a_replay_idx: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_REPLAY |-> CNT_W'(idx_ff) < cnt_ff)
      else $error("replay index past held bytes");

endmodule
